[sv/noq_pkg.sv]
// Package for the name ownership queue: shared constants, codes and item types.
// Used by the channel interfaces, the row update logic and the top level.
`timescale 1ns / 1ps

package noq_pkg;

  // Field widths fixed by the item format
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned NAME_W   = 4;
  localparam int unsigned CLIENT_W = 6;
  localparam int unsigned STATUS_W = 3;

  // Default sizing of the table
  localparam int unsigned NAMES_DEF       = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 8;

  // Client numbers at or above this bound are rejected
  localparam int unsigned CLIENTS = 64;

  // Operation codes; the unused code behaves as a lookup
  localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_SUCCESS   = 3'd0,
    ST_ALREADY   = 3'd1,
    ST_IN_QUEUE  = 3'd2,
    ST_FAILED    = 3'd3,
    ST_INVALID   = 3'd4,
    ST_NOT_OWNER = 3'd5
  } noq_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CALC
  } noq_state_e;

  // One queue slot: client and its allow-replacement mark
  typedef struct packed {
    logic [CLIENT_W-1:0] client;
    logic                allow;
  } noq_entry_t;

  localparam int unsigned ENTRY_W = $bits(noq_entry_t);

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [NAME_W-1:0]   name_id;
    logic [CLIENT_W-1:0] client_id;
    logic                allow_replacement;
    logic                replace_existing;
    logic                do_not_queue;
  } noq_req_t;

  typedef struct packed {
    noq_status_e         status;
    logic                owner_changed;
    logic                old_owner_valid;
    logic [CLIENT_W-1:0] old_owner;
    logic                new_owner_valid;
    logic [CLIENT_W-1:0] new_owner;
  } noq_rsp_t;

endpackage

[sv/noq_ifs.sv]
// Valid/ready channel interfaces for request items and result items.
// Depends on noq_pkg for the field widths.
`timescale 1ns / 1ps

interface noq_req_if;
  import noq_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [NAME_W-1:0]   name_id;
  logic [CLIENT_W-1:0] client_id;
  logic                allow_replacement;
  logic                replace_existing;
  logic                do_not_queue;

  modport source (
    output valid, func, name_id, client_id, allow_replacement, replace_existing,
           do_not_queue,
    input  ready
  );
  modport sink (
    input  valid, func, name_id, client_id, allow_replacement, replace_existing,
           do_not_queue,
    output ready
  );
endinterface

interface noq_rsp_if;
  import noq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                owner_changed;
  logic                old_owner_valid;
  logic [CLIENT_W-1:0] old_owner;
  logic                new_owner_valid;
  logic [CLIENT_W-1:0] new_owner;

  modport source (
    output valid, status, owner_changed, old_owner_valid, old_owner, new_owner_valid,
           new_owner,
    input  ready
  );
  modport sink (
    input  valid, status, owner_changed, old_owner_valid, old_owner, new_owner_valid,
           new_owner,
    output ready
  );
endinterface

[sv/noq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module noq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/noq_row_update.sv]
// Update of one name's queue row: client search, removal shift, push and owner swap.
// Depends on noq_pkg for entry, item and status types.
`timescale 1ns / 1ps

module noq_row_update #(
  parameter int unsigned QUEUE_DEPTH = noq_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH)
) (
  input  noq_pkg::noq_entry_t [QUEUE_DEPTH-1:0] row_i,
  input  logic [CntW-1:0]                       cnt_i,
  input  noq_pkg::noq_req_t                     req_i,
  input  logic                                  name_ok_i,
  output noq_pkg::noq_entry_t [QUEUE_DEPTH-1:0] row_o,
  output logic [CntW-1:0]                       cnt_o,
  output noq_pkg::noq_rsp_t                     rsp_o
);
  import noq_pkg::*;

  logic [QUEUE_DEPTH-1:0]              match;
  logic                                found;
  logic [IdxW-1:0]                     idx;
  noq_entry_t [QUEUE_DEPTH-1:0]        rem_row;
  logic                                full;
  logic                                client_ok;
  noq_entry_t                          new_ent;
  noq_entry_t [QUEUE_DEPTH-1:0]        row_d;
  logic [CntW-1:0]                     cnt_d;
  noq_status_e                         status;
  logic                                changed;
  logic                                old_valid;
  logic [CLIENT_W-1:0]                 old_owner;

  assign new_ent   = '{client: req_i.client_id, allow: req_i.allow_replacement};
  assign full      = (cnt_i == CntW'(QUEUE_DEPTH));
  assign client_ok = (32'(req_i.client_id) < 32'(CLIENTS));

  // Search the live part of the queue for the client
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      match[i] = (CntW'(i) < cnt_i) && (row_i[i].client == req_i.client_id);
    end
  end

  assign found = |match;

  // Pick the lowest matching slot
  always_comb begin
    idx = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        idx = IdxW'(i);
      end
    end
  end

  // Row with the matching slot removed and later slots moved up
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if ((i < QUEUE_DEPTH - 1) && (IdxW'(i) >= idx)) begin
        rem_row[i] = row_i[(i + 1) % QUEUE_DEPTH];
      end else begin
        rem_row[i] = row_i[i];
      end
    end
  end

  // Apply the operation
  always_comb begin
    row_d     = row_i;
    cnt_d     = cnt_i;
    status    = ST_SUCCESS;
    changed   = 1'b0;
    old_valid = 1'b0;
    old_owner = '0;
    case (req_i.func)
      FUNC_REQUEST: begin
        if (!client_ok) begin
          status = ST_FAILED;
        end else if (cnt_i == '0) begin
          row_d[0] = new_ent;
          cnt_d    = CntW'(1);
          changed  = 1'b1;
        end else if (row_i[0].client == req_i.client_id) begin
          row_d[0].allow = req_i.allow_replacement;
          status         = ST_ALREADY;
        end else if (req_i.replace_existing && row_i[0].allow) begin
          // Head cannot match here, so a hit lies behind it
          if (found) begin
            row_d = rem_row;
            cnt_d = cnt_i - CntW'(1);
          end
          row_d[0]  = new_ent;
          old_valid = 1'b1;
          old_owner = row_i[0].client;
          changed   = 1'b1;
        end else if (!req_i.do_not_queue) begin
          if (found) begin
            row_d[idx].allow = req_i.allow_replacement;
            status           = ST_IN_QUEUE;
          end else if (!full) begin
            row_d[cnt_i[IdxW-1:0]] = new_ent;
            cnt_d                  = cnt_i + CntW'(1);
            status                 = ST_IN_QUEUE;
          end else begin
            status = ST_FAILED;
          end
        end else begin
          if (found) begin
            row_d = rem_row;
            cnt_d = cnt_i - CntW'(1);
          end
          status = ST_FAILED;
        end
      end
      FUNC_RELEASE: begin
        if (cnt_i == '0) begin
          status = ST_INVALID;
        end else if (!found) begin
          status = ST_NOT_OWNER;
        end else begin
          row_d = rem_row;
          cnt_d = cnt_i - CntW'(1);
          if (idx == '0) begin
            changed   = 1'b1;
            old_valid = 1'b1;
            old_owner = req_i.client_id;
          end
        end
      end
      default: begin
        status = (cnt_i == '0) ? ST_INVALID : ST_SUCCESS;
      end
    endcase
  end

  // Drive the result; an out-of-range name reports invalid and nothing else
  always_comb begin
    row_o = row_d;
    cnt_o = cnt_d;
    if (!name_ok_i) begin
      rsp_o = '{status: ST_INVALID, owner_changed: 1'b0, old_owner_valid: 1'b0,
                old_owner: '0, new_owner_valid: 1'b0, new_owner: '0};
    end else begin
      rsp_o.status          = status;
      rsp_o.owner_changed   = changed;
      rsp_o.old_owner_valid = old_valid;
      rsp_o.old_owner       = old_owner;
      rsp_o.new_owner_valid = (cnt_d != '0);
      rsp_o.new_owner       = (cnt_d != '0) ? row_d[0].client : '0;
    end
  end

endmodule

[sv/name_ownership_queue.sv]
// Top level of the name ownership queue: sequencer, row memory and result register.
// Depends on noq_pkg, noq_ifs, noq_ram and noq_row_update.
//
//   channel | direction | handshake      | carries
//   req_i   | in        | valid / ready  | func, name_id, client_id, request flags
//   rsp_o   | out       | valid / ready  | status, owner change, old and new owner
//
// Each item passes through accept, row read, then update and write-back of the
// row. The read-modify-write of the single row memory handles one item at a time.
// Reset clears the row valid bits at once; an invalid row reads as an empty queue.
// A new item is accepted while a result waits in the output register; the update
// then holds until that register is taken.
`timescale 1ns / 1ps

module name_ownership_queue #(
  parameter int unsigned NAMES       = noq_pkg::NAMES_DEF,
  parameter int unsigned QUEUE_DEPTH = noq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  noq_req_if.sink   req_i,
  noq_rsp_if.source rsp_o
);
  import noq_pkg::*;

  localparam int unsigned NameW = (NAMES > 1) ? $clog2(NAMES) : 1;
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RowW  = CntW + QUEUE_DEPTH * ENTRY_W;

  noq_state_e                    state_q, state_d;
  noq_req_t                      req_q;
  noq_rsp_t                      rsp_q, rsp_d;
  logic                          rsp_valid_q, rsp_valid_d;
  logic [NAMES-1:0]              vld_q, vld_d;

  logic                          req_fire;
  logic                          out_free;
  logic                          ram_re;
  logic                          ram_we;
  logic                          load_rsp;
  logic                          name_ok;
  logic [NameW-1:0]              row_idx;
  logic                          row_valid;
  logic [RowW-1:0]               ram_rdata;
  logic [RowW-1:0]               ram_wdata;
  logic [CntW-1:0]               cnt_rd;
  noq_entry_t [QUEUE_DEPTH-1:0]  row_rd;
  logic [CntW-1:0]               cnt_wr;
  noq_entry_t [QUEUE_DEPTH-1:0]  row_wr;
  noq_rsp_t                      upd_rsp;

  assign req_fire = req_i.valid && req_i.ready;
  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign name_ok  = (32'(req_q.name_id) < 32'(NAMES));
  assign row_idx  = NameW'(req_q.name_id);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (req_fire) state_d = S_READ;
      S_READ: state_d = S_CALC;
      S_CALC: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    req_i.ready = 1'b0;
    ram_re      = 1'b0;
    load_rsp    = 1'b0;
    unique case (state_q)
      S_IDLE: req_i.ready = 1'b1;
      S_READ: ram_re = 1'b1;
      S_CALC: load_rsp = out_free;
      default: ;
    endcase
  end

  assign ram_we = load_rsp && name_ok;

  // Unpack the row; an unwritten row is an empty queue
  assign row_valid = name_ok && vld_q[row_idx];
  assign cnt_rd    = row_valid ? ram_rdata[RowW-1 -: CntW] : '0;
  assign row_rd    = ram_rdata[QUEUE_DEPTH*ENTRY_W-1:0];
  assign ram_wdata = {cnt_wr, row_wr};

  noq_ram #(
    .WIDTH (RowW),
    .DEPTH (NAMES)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (row_idx),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (row_idx),
    .rdata_o (ram_rdata)
  );

  noq_row_update #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_row_update (
    .row_i     (row_rd),
    .cnt_i     (cnt_rd),
    .req_i     (req_q),
    .name_ok_i (name_ok),
    .row_o     (row_wr),
    .cnt_o     (cnt_wr),
    .rsp_o     (upd_rsp)
  );

  // Mark rows valid on write-back
  always_comb begin
    vld_d = vld_q;
    if (ram_we) begin
      vld_d[row_idx] = 1'b1;
    end
  end

  // Load or drain the result register
  always_comb begin
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q;
    if (load_rsp) begin
      rsp_d       = upd_rsp;
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      vld_q       <= '0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      vld_q       <= vld_d;
    end
  end

  // Capture the accepted item and hold the result payload
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q <= '{func: req_i.func, name_id: req_i.name_id, client_id: req_i.client_id,
                 allow_replacement: req_i.allow_replacement,
                 replace_existing: req_i.replace_existing,
                 do_not_queue: req_i.do_not_queue};
    end
    rsp_q <= rsp_d;
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = rsp_q.status;
  assign rsp_o.owner_changed   = rsp_q.owner_changed;
  assign rsp_o.old_owner_valid = rsp_q.old_owner_valid;
  assign rsp_o.old_owner       = rsp_q.old_owner;
  assign rsp_o.new_owner_valid = rsp_q.new_owner_valid;
  assign rsp_o.new_owner       = rsp_q.new_owner;

endmodule
